@@ rtl/stl_pkg.sv @@
package stl_pkg;

    // Default text length limit; offsets saturate at the smaller of this and 65535.
    localparam int unsigned STL_TEXT_LENGTH_MAX = 32'd65535;

    localparam int unsigned POS_W  = 16;
    localparam int unsigned KIND_W = 3;

    // Result queue depth; one byte can cause two results.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_LPAREN    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RPAREN    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_QUOTE     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NUMBER    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SYMBOL    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BAD_START = 3'd5;
    localparam logic [KIND_W-1:0] KIND_NO_DIGIT  = 3'd6;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_INT  = 5'b00010,
        MODE_DOT  = 5'b00100,
        MODE_FRAC = 5'b01000,
        MODE_SYM  = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  start_offset;
        logic [POS_W-1:0]  end_offset;
        logic              last_of_run;
    } t_result;

    // Results produced by one accepted byte, in order.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push_bus;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

@@ rtl/sexpr_token_lexer.sv @@
// S-expression token lexer. Each input item is one text byte; byte 0 ends the
// text, flushes any pending token and returns the offset counter to zero.
// Each result item is a token or an error with its start offset and exclusive
// end offset: ( ) and ' are one-byte tokens, numbers are digits with an
// optional dot and more digits, and symbols are other runs of bytes. A byte
// that ends a token may also start one, so one byte can give two results;
// o_last_of_run marks the final result of each byte. The byte decode is
// combinational and the scan state is registered, so a byte is accepted
// every cycle while the four-entry result queue has room for two results.
// The queue drains one result per cycle while i_stall is low, so a run of
// bytes that each give two results stalls the input between bytes. Offsets
// saturate at min(TEXT_LENGTH_MAX, 65535); no start-up sweep after reset.
module sexpr_token_lexer
    import stl_pkg::*;
#(
    parameter int unsigned TEXT_LENGTH_MAX = STL_TEXT_LENGTH_MAX
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_char_code,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [KIND_W-1:0] o_kind,
    output logic [POS_W-1:0]  o_start_offset,
    output logic [POS_W-1:0]  o_end_offset,
    output logic              o_last_of_run
);

    t_push_bus push;
    t_result   head;
    logic      in_accept;
    logic      full2;

    // The stall depends only on the registered queue fill, never on i_valid.
    assign o_stall   = full2;
    assign in_accept = i_valid && !full2;

    // Scan state and per-byte decode.
    stl_lexer_core #(
        .TEXT_LENGTH_MAX(TEXT_LENGTH_MAX)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_char_code (i_char_code),
        .o_push      (push)
    );

    // Result queue; it also decouples the output stall from the input side.
    stl_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_full2 (full2),
        .o_res   (head)
    );

    assign o_kind         = head.kind;
    assign o_start_offset = head.start_offset;
    assign o_end_offset   = head.end_offset;
    assign o_last_of_run  = head.last_of_run;

endmodule

@@ rtl/stl_lexer_core.sv @@
module stl_lexer_core
    import stl_pkg::*;
#(
    parameter int unsigned TEXT_LENGTH_MAX = STL_TEXT_LENGTH_MAX
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_char_code,
    output t_push_bus        o_push
);

    localparam logic [POS_W-1:0] POS_LIMIT =
        POS_W'((TEXT_LENGTH_MAX > 32'd65535) ? 32'd65535 : TEXT_LENGTH_MAX);

    t_mode            r_mode,  n_mode;
    logic [POS_W-1:0] r_tstart, n_tstart;
    logic [POS_W-1:0] r_pos,   n_pos;

    logic [POS_W-1:0]  pos_inc;
    logic              p_vld, s_vld, again;
    logic [KIND_W-1:0] p_kind, s_kind;
    logic [POS_W-1:0]  p_start, p_end;
    logic              sym_end;

    assign pos_inc = (r_pos >= POS_LIMIT) ? POS_LIMIT : r_pos + POS_W'(1);
    assign sym_end = is_space(i_char_code) || (i_char_code == CH_LPAREN)
                  || (i_char_code == CH_RPAREN) || (i_char_code == CH_QUOTE)
                  || (i_char_code == CH_DOT);

    always_comb begin
        n_mode   = r_mode;
        n_tstart = r_tstart;
        n_pos    = r_pos;
        p_vld    = 1'b0;
        p_kind   = KIND_NUMBER;
        p_start  = r_tstart;
        p_end    = r_pos;
        s_vld    = 1'b0;
        s_kind   = KIND_LPAREN;
        again    = 1'b0;

        if (i_accept) begin
            if (i_char_code == CH_NUL) begin
                // End of text: flush the pending token, then back to reset.
                case (r_mode)
                    MODE_INT, MODE_FRAC: begin
                        p_vld = 1'b1;
                    end
                    MODE_SYM: begin
                        p_vld  = 1'b1;
                        p_kind = KIND_SYMBOL;
                    end
                    MODE_DOT: begin
                        p_vld   = 1'b1;
                        p_kind  = KIND_NO_DIGIT;
                        p_start = r_pos;
                        p_end   = pos_inc;
                    end
                    default: begin
                    end
                endcase
                n_mode   = MODE_IDLE;
                n_tstart = '0;
                n_pos    = '0;
            end else begin
                case (r_mode)
                    MODE_INT: begin
                        if (i_char_code == CH_DOT) begin
                            n_mode = MODE_DOT;
                        end else if (!is_digit(i_char_code)) begin
                            p_vld  = 1'b1;
                            n_mode = MODE_IDLE;
                            again  = 1'b1;
                        end
                    end
                    MODE_DOT: begin
                        if (is_digit(i_char_code)) begin
                            n_mode = MODE_FRAC;
                        end else begin
                            // The byte after the dot is swallowed.
                            p_vld   = 1'b1;
                            p_kind  = KIND_NO_DIGIT;
                            p_start = r_pos;
                            p_end   = pos_inc;
                            n_mode  = MODE_IDLE;
                        end
                    end
                    MODE_FRAC: begin
                        if (!is_digit(i_char_code)) begin
                            p_vld  = 1'b1;
                            n_mode = MODE_IDLE;
                            again  = 1'b1;
                        end
                    end
                    MODE_SYM: begin
                        if (sym_end) begin
                            p_vld  = 1'b1;
                            p_kind = KIND_SYMBOL;
                            n_mode = MODE_IDLE;
                            again  = 1'b1;
                        end
                    end
                    default: begin
                        n_mode = MODE_IDLE;
                        again  = 1'b1;
                    end
                endcase

                if (again) begin
                    if (i_char_code == CH_LPAREN) begin
                        s_vld  = 1'b1;
                        s_kind = KIND_LPAREN;
                    end else if (i_char_code == CH_RPAREN) begin
                        s_vld  = 1'b1;
                        s_kind = KIND_RPAREN;
                    end else if (i_char_code == CH_QUOTE) begin
                        s_vld  = 1'b1;
                        s_kind = KIND_QUOTE;
                    end else if (is_digit(i_char_code)) begin
                        n_mode   = MODE_INT;
                        n_tstart = r_pos;
                    end else if (is_space(i_char_code)) begin
                        n_mode = MODE_IDLE;
                    end else if (i_char_code == CH_DOT) begin
                        s_vld  = 1'b1;
                        s_kind = KIND_BAD_START;
                    end else begin
                        n_mode   = MODE_SYM;
                        n_tstart = r_pos;
                    end
                end
                n_pos = pos_inc;
            end
        end
    end

    always_comb begin
        o_push.cnt = {1'b0, p_vld} + {1'b0, s_vld};
        if (p_vld) begin
            o_push.res0.kind         = p_kind;
            o_push.res0.start_offset = p_start;
            o_push.res0.end_offset   = p_end;
        end else begin
            o_push.res0.kind         = s_kind;
            o_push.res0.start_offset = r_pos;
            o_push.res0.end_offset   = pos_inc;
        end
        o_push.res0.last_of_run  = !(p_vld && s_vld);
        o_push.res1.kind         = s_kind;
        o_push.res1.start_offset = r_pos;
        o_push.res1.end_offset   = pos_inc;
        o_push.res1.last_of_run  = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_tstart <= '0;
            r_pos    <= '0;
        end else begin
            r_mode   <= n_mode;
            r_tstart <= n_tstart;
            r_pos    <= n_pos;
        end
    end

`ifndef SYNTH
    a_eot_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_char_code == CH_NUL))
        |=> (r_pos == '0) && (r_mode == MODE_IDLE))
        else $error("end of text did not return the lexer to its start");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_char_code != CH_NUL) && (r_pos < POS_LIMIT))
        |=> (r_pos == $past(r_pos) + POS_W'(1)))
        else $error("position did not advance by one byte");
`endif

endmodule

@@ rtl/stl_result_fifo.sv @@
module stl_result_fifo
    import stl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push_bus i_push,
    input  logic      i_pop,
    output logic      o_valid,
    output logic      o_full2,
    output t_result   o_res
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, n_wr;
    logic [FIFO_AW-1:0]   r_rd, n_rd;
    logic [FIFO_CW-1:0]   r_count, n_count;
    logic                 pop_ok;

    assign o_valid = (r_count != '0);
    // Stall the producer unless there is room for two results.
    assign o_full2 = (r_count > FIFO_CW'(FIFO_DEPTH - 2));
    assign o_res   = r_mem[r_rd];
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr + FIFO_AW'(i_push.cnt);
        n_rd    = r_rd + FIFO_AW'(pop_ok);
        n_count = r_count + FIFO_CW'(i_push.cnt) - FIFO_CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + FIFO_AW'(1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

`ifndef SYNTH
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> (r_count <= FIFO_CW'(FIFO_DEPTH - 2)))
        else $error("results pushed without room for them");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_ok && (r_count == FIFO_CW'(1)) && (i_push.cnt == 2'd0))
        |=> !o_valid)
        else $error("queue still valid after its last result was taken");
`endif

endmodule
